### src/sorm_pkg.sv
// Shared types, codes and constants for the spiral order matrix reader.
package sorm_pkg;

   // Default geometry and data width
   localparam int MAX_ROWS_DEF    = 32;
   localparam int MAX_COLUMNS_DEF = 32;
   localparam int DATA_WIDTH_DEF  = 32;

   // Fixed field widths
   localparam int OP_W    = 2;   // operation code
   localparam int CFG_W   = 6;   // row and column count registers
   localparam int CSR_W   = 1;   // register index
   localparam int IDX_W   = 5;   // reported row and column index
   localparam int CNT_W   = 12;  // element counts, up to 63*63
   localparam int BND_W   = 7;   // signed ring level and bounds

   typedef logic signed [BND_W-1:0] bnd_type;

   // Operation codes
   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_EMIT  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   // Register indexes
   typedef enum logic [CSR_W-1:0] {
      CSR_ROW_COUNT    = 1'b0,
      CSR_COLUMN_COUNT = 1'b1
   } csr_type;

   // Legs of one spiral ring
   typedef enum logic [1:0] {
      LEG_TOP    = 2'd0,
      LEG_RIGHT  = 2'd1,
      LEG_BOTTOM = 2'd2,
      LEG_LEFT   = 2'd3
   } leg_type;

endpackage

### src/spiral_order_matrix_reader_top.sv
// An emit word is read from the store at acceptance into the read-in-flight register; its result
// word then moves into the result register. Throughput is one word per cycle; input stalls only
// while a store read is in flight and the result register still waits to be taken.
// Loads and clears give no result word. Reset (synchronous) clears the registers,
// counters and spiral cursor; the element store is not cleared and holds unknown data.
// Top level of the spiral order matrix reader.
module spiral_order_matrix_reader_top #(
   parameter int MAX_ROWS    = sorm_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLUMNS = sorm_pkg::MAX_COLUMNS_DEF,
   parameter int DATA_WIDTH  = sorm_pkg::DATA_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sorm_pkg::CSR_W-1:0]         csr_index,
   input  logic [sorm_pkg::CFG_W-1:0]         csr_data,
   // request
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [sorm_pkg::OP_W-1:0]          req_operation,
   input  logic signed [DATA_WIDTH-1:0]       req_element,
   // response
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [DATA_WIDTH-1:0]       rsp_element_out,
   output logic [sorm_pkg::IDX_W-1:0]         rsp_row_index,
   output logic [sorm_pkg::IDX_W-1:0]         rsp_column_index,
   output logic                               rsp_is_last,
   output logic                               rsp_is_valid
);

   localparam int STORE_DEPTH = MAX_ROWS * MAX_COLUMNS;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CFG_W       = sorm_pkg::CFG_W;
   localparam int CNT_W       = sorm_pkg::CNT_W;
   localparam int IDX_W       = sorm_pkg::IDX_W;

   // Element store
   logic [DATA_WIDTH-1:0] store [STORE_DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic                  wr_en;
   logic                  rd_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [ADDR_W-1:0]     rd_addr;

   // Configuration registers
   logic [CFG_W-1:0] row_count_ff;
   logic [CFG_W-1:0] column_count_ff;

   // Counters and spiral cursor
   logic [CNT_W-1:0]  loaded_count_ff,  loaded_count_in;
   logic [CNT_W-1:0]  emitted_count_ff, emitted_count_in;
   sorm_pkg::bnd_type ring_level_ff,    ring_level_in;
   sorm_pkg::bnd_type bottom_bound_ff,  bottom_bound_in;
   sorm_pkg::bnd_type right_bound_ff,   right_bound_in;
   logic [CFG_W-1:0]  cursor_row_ff,    cursor_row_in;
   logic [CFG_W-1:0]  cursor_column_ff, cursor_column_in;
   sorm_pkg::leg_type leg_ff,           leg_in;

   // Read in flight
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  pend_row_ff;
   logic [IDX_W-1:0]  pend_col_ff;
   logic              pend_last_ff;
   logic              pend_ok_ff;

   // Result register
   logic                  rsp_valid_ff;
   logic [DATA_WIDTH-1:0] rsp_element_ff;
   logic [IDX_W-1:0]      rsp_row_ff;
   logic [IDX_W-1:0]      rsp_col_ff;
   logic                  rsp_last_ff;
   logic                  rsp_ok_ff;

   // Handshake
   logic             slot_free;
   logic             req_acc;
   logic             emit_acc;
   sorm_pkg::op_type op;

   // Geometry in use
   logic [CFG_W-1:0] rows_used;
   logic [CFG_W-1:0] cols_used;
   logic [CNT_W-1:0] total;
   sorm_pkg::bnd_type start_bottom;
   sorm_pkg::bnd_type start_right;

   // Effective cursor (restarted when nothing has been emitted yet)
   sorm_pkg::bnd_type eff_ring, eff_bottom, eff_right;
   logic [CFG_W-1:0]  eff_row, eff_col;
   sorm_pkg::leg_type eff_leg;
   logic              eff_done;
   logic              emit_ok;
   logic [CNT_W-1:0]  emit_addr;

   // Advanced cursor
   sorm_pkg::bnd_type adv_ring, adv_bottom, adv_right;
   sorm_pkg::bnd_type adv_row, adv_col;
   sorm_pkg::leg_type adv_leg;
   logic              adv_moved;
   logic [2:0]        adv_stage;
   logic              adv_done;
   logic              emit_last;
   sorm_pkg::bnd_type cr, cc;

   // Handshake
   assign csr_ready = 1'b1;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = !pend_ff || slot_free;
   assign req_acc   = req_valid && req_ready;
   assign op        = sorm_pkg::op_type'(req_operation);
   assign emit_acc  = req_acc && (op == sorm_pkg::OP_EMIT);

   // Saturated geometry
   assign rows_used = (int'(row_count_ff) > MAX_ROWS) ? CFG_W'(MAX_ROWS) : row_count_ff;
   assign cols_used = (int'(column_count_ff) > MAX_COLUMNS) ?
                      CFG_W'(MAX_COLUMNS) : column_count_ff;
   assign total     = CNT_W'(rows_used) * CNT_W'(cols_used);
   assign start_bottom = $signed({1'b0, rows_used}) - sorm_pkg::bnd_type'(1);
   assign start_right  = $signed({1'b0, cols_used}) - sorm_pkg::bnd_type'(1);

   // Effective cursor for this emit
   always_comb begin
      if (emitted_count_ff == '0) begin
         eff_ring   = '0;
         eff_bottom = start_bottom;
         eff_right  = start_right;
         eff_row    = '0;
         eff_col    = '0;
         eff_leg    = sorm_pkg::LEG_TOP;
      end else begin
         eff_ring   = ring_level_ff;
         eff_bottom = bottom_bound_ff;
         eff_right  = right_bound_ff;
         eff_row    = cursor_row_ff;
         eff_col    = cursor_column_ff;
         eff_leg    = leg_ff;
      end
      eff_done  = (eff_ring > eff_bottom) || (eff_ring > eff_right);
      emit_ok   = (total != '0) && (emitted_count_ff < total) && !eff_done;
      emit_addr = CNT_W'(eff_row) * CNT_W'(cols_used) + CNT_W'(eff_col);
   end

   // One spiral step: walk the current leg, else turn to the next leg or ring
   always_comb begin
      cr         = $signed({1'b0, eff_row});
      cc         = $signed({1'b0, eff_col});
      adv_ring   = eff_ring;
      adv_bottom = eff_bottom;
      adv_right  = eff_right;
      adv_row    = cr;
      adv_col    = cc;
      adv_leg    = eff_leg;
      adv_moved  = 1'b0;
      adv_stage  = 3'd1;
      unique case (eff_leg)
         sorm_pkg::LEG_TOP: begin
            if (cc < eff_right) begin
               adv_col   = cc + sorm_pkg::bnd_type'(1);
               adv_moved = 1'b1;
            end
            adv_stage = 3'd1;
         end
         sorm_pkg::LEG_RIGHT: begin
            if (cr < eff_bottom) begin
               adv_row   = cr + sorm_pkg::bnd_type'(1);
               adv_moved = 1'b1;
            end
            adv_stage = 3'd2;
         end
         sorm_pkg::LEG_BOTTOM: begin
            if (cc > eff_ring) begin
               adv_col   = cc - sorm_pkg::bnd_type'(1);
               adv_moved = 1'b1;
            end
            adv_stage = 3'd3;
         end
         sorm_pkg::LEG_LEFT: begin
            if (cr > eff_ring + sorm_pkg::bnd_type'(1)) begin
               adv_row   = cr - sorm_pkg::bnd_type'(1);
               adv_moved = 1'b1;
            end
            adv_stage = 3'd4;
         end
         default: adv_stage = 3'd4;
      endcase
      if (!adv_moved) begin
         priority if (adv_stage <= 3'd1 &&
                      eff_ring + sorm_pkg::bnd_type'(1) <= eff_bottom) begin
            adv_leg = sorm_pkg::LEG_RIGHT;
            adv_row = eff_ring + sorm_pkg::bnd_type'(1);
            adv_col = eff_right;
         end else if (adv_stage <= 3'd2 && eff_ring != eff_bottom &&
                      eff_right - sorm_pkg::bnd_type'(1) >= eff_ring) begin
            adv_leg = sorm_pkg::LEG_BOTTOM;
            adv_row = eff_bottom;
            adv_col = eff_right - sorm_pkg::bnd_type'(1);
         end else if (adv_stage <= 3'd3 && eff_ring != eff_right &&
                      eff_bottom - sorm_pkg::bnd_type'(1) >=
                      eff_ring + sorm_pkg::bnd_type'(1)) begin
            adv_leg = sorm_pkg::LEG_LEFT;
            adv_row = eff_bottom - sorm_pkg::bnd_type'(1);
            adv_col = eff_ring;
         end else begin
            // ring finished: shrink bounds, stop decrementing once exhausted
            adv_ring   = eff_ring + sorm_pkg::bnd_type'(1);
            adv_bottom = eff_bottom - sorm_pkg::bnd_type'(1);
            if (!(adv_ring > adv_bottom)) begin
               adv_right = eff_right - sorm_pkg::bnd_type'(1);
               if (!(adv_ring > adv_right)) begin
                  adv_leg = sorm_pkg::LEG_TOP;
                  adv_row = adv_ring;
                  adv_col = adv_ring;
               end
            end
         end
      end
      adv_done  = (adv_ring > adv_bottom) || (adv_ring > adv_right);
      emit_last = (emitted_count_ff + CNT_W'(1) >= total) || adv_done;
   end

   // Next state of counters and cursor
   always_comb begin
      loaded_count_in  = loaded_count_ff;
      emitted_count_in = emitted_count_ff;
      ring_level_in    = ring_level_ff;
      bottom_bound_in  = bottom_bound_ff;
      right_bound_in   = right_bound_ff;
      cursor_row_in    = cursor_row_ff;
      cursor_column_in = cursor_column_ff;
      leg_in           = leg_ff;
      wr_en            = 1'b0;
      rd_en            = 1'b0;
      if (req_acc) begin
         unique case (op)
            sorm_pkg::OP_LOAD: begin
               if (loaded_count_ff < total && int'(loaded_count_ff) < STORE_DEPTH) begin
                  wr_en           = 1'b1;
                  loaded_count_in = loaded_count_ff + CNT_W'(1);
               end
            end
            sorm_pkg::OP_EMIT: begin
               if (emit_ok) begin
                  rd_en            = 1'b1;
                  emitted_count_in = emitted_count_ff + CNT_W'(1);
                  ring_level_in    = adv_ring;
                  bottom_bound_in  = adv_bottom;
                  right_bound_in   = adv_right;
                  cursor_row_in    = adv_row[CFG_W-1:0];
                  cursor_column_in = adv_col[CFG_W-1:0];
                  leg_in           = adv_leg;
               end else begin
                  ring_level_in    = eff_ring;
                  bottom_bound_in  = eff_bottom;
                  right_bound_in   = eff_right;
                  cursor_row_in    = eff_row;
                  cursor_column_in = eff_col;
                  leg_in           = eff_leg;
               end
            end
            sorm_pkg::OP_CLEAR: begin
               loaded_count_in  = '0;
               emitted_count_in = '0;
               ring_level_in    = '0;
               bottom_bound_in  = start_bottom;
               right_bound_in   = start_right;
               cursor_row_in    = '0;
               cursor_column_in = '0;
               leg_in           = sorm_pkg::LEG_TOP;
            end
            default: ;
         endcase
      end
   end

   assign wr_addr = ADDR_W'(loaded_count_ff);
   assign rd_addr = ADDR_W'(emit_addr);
   assign pend_in = emit_acc || (pend_ff && !slot_free);

   // Store write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= req_element;
      end
      if (rd_en) begin
         rd_data_ff <= store[rd_addr];
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= '0;
         column_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (sorm_pkg::csr_type'(csr_index))
            sorm_pkg::CSR_ROW_COUNT:    row_count_ff    <= csr_data;
            sorm_pkg::CSR_COLUMN_COUNT: column_count_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Counters and cursor
   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_count_ff  <= '0;
         emitted_count_ff <= '0;
         ring_level_ff    <= '0;
         bottom_bound_ff  <= -sorm_pkg::bnd_type'(1);
         right_bound_ff   <= -sorm_pkg::bnd_type'(1);
         cursor_row_ff    <= '0;
         cursor_column_ff <= '0;
         leg_ff           <= sorm_pkg::LEG_TOP;
      end else begin
         loaded_count_ff  <= loaded_count_in;
         emitted_count_ff <= emitted_count_in;
         ring_level_ff    <= ring_level_in;
         bottom_bound_ff  <= bottom_bound_in;
         right_bound_ff   <= right_bound_in;
         cursor_row_ff    <= cursor_row_in;
         cursor_column_ff <= cursor_column_in;
         leg_ff           <= leg_in;
      end
   end

   // Read in flight: position and flags wait beside the store read
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
      if (emit_acc) begin
         pend_row_ff  <= eff_row[IDX_W-1:0];
         pend_col_ff  <= eff_col[IDX_W-1:0];
         pend_last_ff <= emit_ok && emit_last;
         pend_ok_ff   <= emit_ok;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pend_ff && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (pend_ff && slot_free) begin
         rsp_element_ff <= pend_ok_ff ? rd_data_ff : '0;
         rsp_row_ff     <= pend_ok_ff ? pend_row_ff : '0;
         rsp_col_ff     <= pend_ok_ff ? pend_col_ff : '0;
         rsp_last_ff    <= pend_last_ff;
         rsp_ok_ff      <= pend_ok_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_element_out  = $signed(rsp_element_ff);
   assign rsp_row_index    = rsp_row_ff;
   assign rsp_column_index = rsp_col_ff;
   assign rsp_is_last      = rsp_last_ff;
   assign rsp_is_valid     = rsp_ok_ff;

   // Checks
   a_pend_held: assert property (@(posedge clock) disable iff (reset)
      pend_ff && !slot_free |=> pend_ff)
      else $error("read in flight dropped while result register full");

   a_rsp_from_pend: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pend_ff))
      else $error("result word appeared without a read in flight");

   a_empty_rsp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> rsp_element_ff == '0 && !rsp_last_ff)
      else $error("empty result carries data");

   a_emit_counts: assert property (@(posedge clock) disable iff (reset)
      emit_acc && emit_ok |=> emitted_count_ff != '0)
      else $error("valid emit did not advance the emitted count");

   a_load_bound: assert property (@(posedge clock) disable iff (reset)
      int'(loaded_count_ff) <= STORE_DEPTH)
      else $error("loaded count beyond store depth");

endmodule
